// ----- design/fxalu_pkg.sv -----
// ----------------------------------------------------------------------------
// fxalu_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Opcodes, widths and the pipeline payload type.
// ----------------------------------------------------------------------------
package fxalu_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	// Divider numerator width: |a| shifted by FRAC_BITS, plus one bit for rounding
	localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
	// Quotient bits retired per divider stage
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int QW        = DIV_STAGES * DIV_STEPS;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} opcode_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              compare_true;
		logic              overflow;
		logic              divide_by_zero;
	} res_t;

	// Divider working word travelling down the pipeline
	typedef struct packed {
		logic [QW-1:0]      rem;   // remainder (low) while numerator shifts out
		logic [QW-1:0]      num;
		logic [QW-1:0]      quo;
		logic [NUM_W-1:0]   den;   // 2*|b|
		logic               neg;
	} div_t;

endpackage

// ----- design/fxalu_if.sv -----
// ----------------------------------------------------------------------------
// fxalu_in_if / fxalu_out_if: valid/ready channels of the fixed-point ALU
// Input carries opcode and operands, output carries the result item.
// ----------------------------------------------------------------------------
interface fxalu_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         opcode;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	modport source (output valid, opcode, operand_a, operand_b, input ready);
	modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fxalu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic               compare_true;
	logic               overflow;
	logic               divide_by_zero;
	modport source (output valid, result, compare_true, overflow, divide_by_zero,
		input ready);
	modport sink (input valid, result, compare_true, overflow, divide_by_zero,
		output ready);
endinterface

// ----- design/fxalu_div_stage.sv -----
// ----------------------------------------------------------------------------
// fxalu_div_stage: one register stage of the restoring divider
// Retires DIV_STEPS quotient bits per stage, stalls with the pipeline.
// ----------------------------------------------------------------------------
module fxalu_div_stage
	import fxalu_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t d,
	output div_t q
);

	div_t nxt;
	logic [QW:0] trial;

	// Shift in numerator bits and subtract the divisor where it fits
	always_comb begin
		nxt = d;
		trial = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {nxt.rem, nxt.num[QW-1]};
			nxt.num = {nxt.num[QW-2:0], 1'b0};
			if (trial >= {{(QW+1-NUM_W){1'b0}}, nxt.den}) begin
				trial = trial - {{(QW+1-NUM_W){1'b0}}, nxt.den};
				nxt.quo = {nxt.quo[QW-2:0], 1'b1};
			end else begin
				nxt.quo = {nxt.quo[QW-2:0], 1'b0};
			end
			nxt.rem = trial[QW-1:0];
		end
	end

	// Advance when the pipeline moves
	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ----- design/fixed_point_q24_8_alu_core.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core: pipelined Q24.8 fixed-point ALU
// Add, sub, mul, div, compares, min/max, inc/dec and conversions.
// ----------------------------------------------------------------------------
// Usage:
//   in  : valid/ready channel carrying opcode, operand_a, operand_b.
//   out : valid/ready channel carrying result and the three flags.
//   Every item produces exactly one result item, in order.
//   The restoring divider retires four quotient bits per stage and sets the
//   depth for every opcode. Stage 1 registers the inputs, stage 2 takes
//   magnitudes, multiplies and sets up the divider, the divider stages
//   follow, the last stage rounds, saturates and selects the result.
//   Throughput is one item per cycle while the output is not stalled.
//   The whole pipeline advances as one: when the receiver stalls with the
//   output register full, every stage holds and in.ready drops; the output
//   register refills in the same cycle it is drained.
//   Reset (arst_n low) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core
	import fxalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fxalu_in_if.sink    in,
	fxalu_out_if.source out
);

	localparam int NST = DIV_STAGES + 3;

	logic en;
	logic [NST-1:0] vld_q;

	// Whole pipeline moves unless the output is full and stalled
	assign en       = !vld_q[NST-1] || out.ready;
	assign in.ready = en;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in.valid};
		end
	end

	// Stage 1: register inputs
	opcode_t            op_s1;
	logic signed [31:0] a_s1, b_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode_t'(in.opcode);
			a_s1  <= in.operand_a;
			b_s1  <= in.operand_b;
		end
	end

	// Stage 2: magnitudes, multiply, and divider setup
	logic signed [63:0] prod_s2;
	div_t               d_s2;
	opcode_t            op_s2;
	logic signed [31:0] a_s2, b_s2;
	logic [31:0]        ma, mb;
	assign ma = a_s1[31] ? 32'(-a_s1) : a_s1;
	assign mb = b_s1[31] ? 32'(-b_s1) : b_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2    <= 64'(a_s1) * 64'(b_s1);
			op_s2      <= op_s1;
			a_s2       <= a_s1;
			b_s2       <= b_s1;
			// quotient of (2*num + den) / (2*den)
			d_s2.rem   <= '0;
			d_s2.num   <= QW'(({1'b0, ma, {FRAC_BITS{1'b0}}} << 1) + {{(NUM_W-32){1'b0}}, mb});
			d_s2.quo   <= '0;
			d_s2.den   <= NUM_W'({mb, 1'b0});
			d_s2.neg   <= a_s1[31] ^ b_s1[31];
		end
	end

	// Divider stages, with side data delayed alongside
	div_t               dv [DIV_STAGES+1];
	opcode_t            op_d [DIV_STAGES+1];
	logic signed [31:0] a_d [DIV_STAGES+1];
	logic signed [31:0] b_d [DIV_STAGES+1];
	logic signed [63:0] p_d [DIV_STAGES+1];
	assign dv[0]   = d_s2;
	assign op_d[0] = op_s2;
	assign a_d[0]  = a_s2;
	assign b_d[0]  = b_s2;
	assign p_d[0]  = prod_s2;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		fxalu_div_stage u_stage (.clk(clk), .en(en), .d(dv[g]), .q(dv[g+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				op_d[g+1] <= op_d[g];
				a_d[g+1]  <= a_d[g];
				b_d[g+1]  <= b_d[g];
				p_d[g+1]  <= p_d[g];
			end
		end
	end

	// Final stage: round, saturate and select
	opcode_t            op_f;
	logic signed [31:0] a_f, b_f;
	logic signed [63:0] p_f;
	div_t               d_f;
	logic [63:0]        pmag, pm_r;
	logic signed [65:0] wide;
	logic signed [33:0] sum;
	logic               cmp, is_wide, sel_sum;
	res_t               r;

	assign op_f = op_d[DIV_STAGES];
	assign a_f  = a_d[DIV_STAGES];
	assign b_f  = b_d[DIV_STAGES];
	assign p_f  = p_d[DIV_STAGES];
	assign d_f  = dv[DIV_STAGES];

	always_comb begin
		pmag    = p_f[63] ? 64'(-p_f) : p_f;
		pm_r    = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		wide    = '0;
		sum     = '0;
		cmp     = 1'b0;
		is_wide = 1'b0;
		sel_sum = 1'b0;
		r       = '0;
		unique case (op_f)
			OP_ADD: begin sum = 34'(a_f) + 34'(b_f); sel_sum = 1'b1; end
			OP_SUB: begin sum = 34'(a_f) - 34'(b_f); sel_sum = 1'b1; end
			OP_INC: begin sum = 34'(a_f) + 34'sd1; sel_sum = 1'b1; end
			OP_DEC: begin sum = 34'(a_f) - 34'sd1; sel_sum = 1'b1; end
			OP_MUL: begin
				wide = p_f[63] ? -$signed({2'b00, pm_r}) : $signed({2'b00, pm_r});
				is_wide = 1'b1;
			end
			OP_DIV: begin
				if (b_f == 32'sd0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					wide = d_f.neg ? -$signed(66'(d_f.quo)) : $signed(66'(d_f.quo));
					is_wide = 1'b1;
				end
			end
			OP_FROM_INT: begin
				wide = $signed(66'(a_f)) <<< FRAC_BITS;
				is_wide = 1'b1;
			end
			OP_GT: cmp = a_f > b_f;
			OP_LT: cmp = a_f < b_f;
			OP_GE: cmp = a_f >= b_f;
			OP_LE: cmp = a_f <= b_f;
			OP_EQ: cmp = a_f == b_f;
			OP_NE: cmp = a_f != b_f;
			OP_MIN: r.result = (a_f <= b_f) ? a_f : b_f;
			OP_MAX: r.result = (a_f >= b_f) ? a_f : b_f;
			OP_TO_INT: r.result = 32'(a_f >>> FRAC_BITS);
			default: r.result = '0;
		endcase
		if (sel_sum) begin
			wide = 66'(sum);
			is_wide = 1'b1;
		end
		if (is_wide) begin
			if (wide > 66'sh7FFFFFFF) begin
				r.result = 32'h7FFFFFFF; r.overflow = 1'b1;
			end else if (wide < -66'sh80000000) begin
				r.result = 32'h80000000; r.overflow = 1'b1;
			end else begin
				r.result = wide[31:0];
			end
		end
		if (op_f == OP_GT || op_f == OP_LT || op_f == OP_GE || op_f == OP_LE ||
			op_f == OP_EQ || op_f == OP_NE) begin
			r.compare_true = cmp;
			r.result = {31'd0, cmp};
		end
	end

	// Output register
	res_t res_s;
	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= r;
		end
	end

	assign out.valid          = vld_q[NST-1];
	assign out.result         = res_s.result;
	assign out.compare_true   = res_s.compare_true;
	assign out.overflow       = res_s.overflow;
	assign out.divide_by_zero = res_s.divide_by_zero;

endmodule
